>>> sv/kts_pkg.sv
// Package for the keyframe track sampler: sizes, command codes and sequencer states.
// No dependencies; used by the top level, the dv checker and the testbench.
`timescale 1ns / 1ps
package kts_pkg;
  localparam int KeyDepth = 256;
  localparam int KeyAw = $clog2(KeyDepth);
  localparam int CntW = KeyAw + 1;
  localparam int CoordW = 32;
  localparam int TimeW = 16;
  localparam int FrameW = 24;
  localparam int CompN = 6;
  localparam int RowW = TimeW + CompN * CoordW;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SRCH = 4'd1;
  localparam logic [3:0] ST_SWAIT = 4'd2;
  localparam logic [3:0] ST_SCMP = 4'd3;
  localparam logic [3:0] ST_RD0 = 4'd4;
  localparam logic [3:0] ST_RD1 = 4'd5;
  localparam logic [3:0] ST_LATB = 4'd6;
  localparam logic [3:0] ST_DECIDE = 4'd7;
  localparam logic [3:0] ST_DIV = 4'd8;
  localparam logic [3:0] ST_MUL = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;
endpackage

>>> sv/kts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module kts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> sv/keyframe_track_sampler_unit.sv
// Keyframe track sampler top level: key table RAM, binary search, serial divider
// and one shared multiplier that blends six components. Uses kts_pkg and kts_ram.
//
//  channel   signals                       direction
//  command   start_i, busy_o, fields       in
//  result    done_o, found_o, out_*        out
//  config    key_count_we_i/key_count_i    in
//
// A write command is taken while idle and leaves the block idle. A sample runs a binary
// search (up to 9 steps for 256 keys, bound by the one RAM read port), fetches the
// bracket and decides, then runs the bit-serial divide and the six blends (each a
// high part product, a low part product and a sum on the shared 33x18 multiplier)
// and finishes; a key returned unchanged skips the divide and the blends.
// Reset clears the sequencer and key_count; the table is undefined until written.
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
module keyframe_track_sampler_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      command_i,
  input  logic [7:0]                key_index_i,
  input  logic [15:0]               key_time_i,
  input  logic signed [31:0]        key_pos_x_i,
  input  logic signed [31:0]        key_pos_y_i,
  input  logic signed [31:0]        key_pos_z_i,
  input  logic signed [31:0]        key_scale_x_i,
  input  logic signed [31:0]        key_scale_y_i,
  input  logic signed [31:0]        key_scale_z_i,
  input  logic [23:0]               frame_i,
  input  logic                      key_count_we_i,
  input  logic [8:0]                key_count_i,
  output logic                      done_o,
  output logic                      found_o,
  output logic signed [31:0]        out_pos_x_o,
  output logic signed [31:0]        out_pos_y_o,
  output logic signed [31:0]        out_pos_z_o,
  output logic signed [31:0]        out_scale_x_o,
  output logic signed [31:0]        out_scale_y_o,
  output logic signed [31:0]        out_scale_z_o
);
  localparam int AW = kts_pkg::KeyAw;
  localparam int CW = kts_pkg::CntW;
  localparam int XW = kts_pkg::CoordW;
  localparam int TW = kts_pkg::TimeW;
  localparam int FW = kts_pkg::FrameW;
  localparam int NC = kts_pkg::CompN;
  localparam int RW = kts_pkg::RowW;

  logic [3:0] state_q, state_d;
  logic [8:0] key_count_q;
  logic [CW-1:0] n_q, n_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, j_q, j_d;
  logic [FW-1:0] frame_q, frame_d;
  logic [AW-1:0] raddr;
  logic [RW-1:0] rdata;
  logic [RW-1:0] row_a_q, row_a_d, row_b_q, row_b_d;
  logic [4:0] cnt_q, cnt_d;
  logic [16:0] w_q, w_d;         // quotient bits shift in here
  logic [FW:0] rem_q, rem_d;     // partial remainder, always below the divisor
  logic [FW-1:0] den_q, den_d;
  logic [2:0] comp_q, comp_d;
  logic phase_q, phase_d;
  logic signed [XW:0] diff_q, diff_d;
  logic signed [2*XW+1:0] acc_q, acc_d;
  logic signed [2*XW+1:0] prod_q;
  logic signed [XW:0] mul_a;
  logic signed [17:0] mul_b;
  logic [XW-1:0] res_q [NC];
  logic [XW-1:0] res_d [NC];
  logic found_q, found_d, done_q, done_d;
  logic we;
  logic [FW-1:0] tmid, ta, tb;
  logic [FW:0] rem_sh;

  // Key count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (key_count_we_i) begin
      key_count_q <= key_count_i;
    end
  end

  assign busy_o = (state_q != kts_pkg::ST_IDLE);
  assign we = start_i && !busy_o && (command_i == kts_pkg::CMD_WRITE);

  // Key table: time plus six components per row.
  kts_ram #(.Width(RW), .Depth(kts_pkg::KeyDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (key_index_i[AW-1:0]),
    .wdata_i ({key_scale_z_i, key_scale_y_i, key_scale_x_i,
               key_pos_z_i, key_pos_y_i, key_pos_x_i, key_time_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign tmid = {rdata[TW-1:0], 8'd0};
  assign ta = {row_a_q[TW-1:0], 8'd0};
  assign tb = {row_b_q[TW-1:0], 8'd0};
  assign rem_sh = {rem_q[FW-1:0], 1'b0};

  // Shared multiplier with registered product.
  always_comb begin
    mul_b = phase_q ? $signed({2'b00, w_q[15:0]}) : $signed({1'b0, w_q});
    mul_a = phase_q ? $signed({{(XW-15){1'b0}}, diff_q[15:0]})
                    : (diff_q >>> 16);
  end
  always_ff @(posedge clk_i) begin
    prod_q <= (2*XW+2)'(mul_a * mul_b);
  end

  // Read address follows the step of the sequencer.
  always_comb begin
    unique case (state_q)
      kts_pkg::ST_SRCH, kts_pkg::ST_SWAIT, kts_pkg::ST_SCMP: raddr = mid_q[AW-1:0];
      kts_pkg::ST_RD0: raddr = (j_q == '0) ? '0 : AW'(j_q - 1'b1);
      default: raddr = j_q[AW-1:0];
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q; n_d = n_q; lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    j_d = j_q; frame_d = frame_q; row_a_d = row_a_q; row_b_d = row_b_q;
    cnt_d = cnt_q; w_d = w_q; rem_d = rem_q; den_d = den_q;
    comp_d = comp_q; phase_d = phase_q; diff_d = diff_q; acc_d = acc_q;
    res_d = res_q; found_d = found_q; done_d = 1'b0;
    unique case (state_q)
      kts_pkg::ST_IDLE: begin
        if (start_i && command_i == kts_pkg::CMD_SAMPLE) begin
          n_d = (key_count_q > 9'(kts_pkg::KeyDepth)) ? CW'(kts_pkg::KeyDepth)
                                                    : CW'(key_count_q);
          frame_d = frame_i;
          lo_d = '0;
          hi_d = n_d;
          for (int c = 0; c < NC; c++) res_d[c] = '0;
          if (n_d == '0) begin
            found_d = 1'b0;
            state_d = kts_pkg::ST_DONE;
          end else begin
            found_d = 1'b1;
            state_d = kts_pkg::ST_SRCH;
          end
        end
      end
      kts_pkg::ST_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d = CW'((lo_q + hi_q) >> 1);
          state_d = kts_pkg::ST_SWAIT;
        end else begin
          j_d = lo_q;
          if (lo_q == n_q) j_d = CW'(n_q - 1'b1);
          state_d = kts_pkg::ST_RD0;
        end
      end
      kts_pkg::ST_SWAIT: state_d = kts_pkg::ST_SCMP;
      kts_pkg::ST_SCMP: begin
        if (tmid < frame_q) lo_d = CW'(mid_q + 1'b1);
        else hi_d = mid_q;
        state_d = kts_pkg::ST_SRCH;
      end
      kts_pkg::ST_RD0: state_d = kts_pkg::ST_RD1;
      kts_pkg::ST_RD1: begin
        row_a_d = rdata;
        state_d = kts_pkg::ST_LATB;
      end
      kts_pkg::ST_LATB: begin
        row_b_d = rdata;
        state_d = kts_pkg::ST_DECIDE;
      end
      kts_pkg::ST_DECIDE: begin
        // Clamped ends and exact hits return key j; a back step returns key j-1.
        if (lo_q == '0 || lo_q == n_q || tb == frame_q) begin
          for (int c = 0; c < NC; c++) res_d[c] = row_b_q[TW+c*XW +: XW];
          state_d = kts_pkg::ST_DONE;
        end else if (frame_q <= ta) begin
          for (int c = 0; c < NC; c++) res_d[c] = row_a_q[TW+c*XW +: XW];
          state_d = kts_pkg::ST_DONE;
        end else begin
          // The numerator is below the divisor, so only 16 quotient bits remain.
          rem_d = {1'b0, FW'(frame_q - ta)};
          den_d = FW'(tb - ta);
          w_d = '0;
          cnt_d = 5'(16 - 1);
          state_d = kts_pkg::ST_DIV;
        end
      end
      kts_pkg::ST_DIV: begin
        // Restoring divide of num*65536 by den, one quotient bit a cycle.
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          w_d = {w_q[15:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          w_d = {w_q[15:0], 1'b0};
        end
        if (cnt_q == '0) begin
          comp_d = '0;
          phase_d = 1'b0;
          cnt_d = '0;
          diff_d = $signed({row_b_q[TW +: XW]}) - $signed({row_a_q[TW +: XW]});
          state_d = kts_pkg::ST_MUL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      kts_pkg::ST_MUL: begin
        // Per component: high part product, then low part product, then sum.
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd0) begin
          phase_d = 1'b1;
        end else if (cnt_q == 5'd1) begin
          acc_d = prod_q;
        end else begin
          res_d[comp_q] = XW'($signed(row_a_q[TW+comp_q*XW +: XW]) + acc_q
                              + (prod_q >>> 16));
          cnt_d = '0;
          phase_d = 1'b0;
          if (comp_q == 3'(NC - 1)) begin
            state_d = kts_pkg::ST_DONE;
          end else begin
            comp_d = comp_q + 1'b1;
            diff_d = $signed(row_b_q[TW+(comp_q+1)*XW +: XW])
                     - $signed(row_a_q[TW+(comp_q+1)*XW +: XW]);
          end
        end
      end
      kts_pkg::ST_DONE: begin
        done_d = 1'b1;
        state_d = kts_pkg::ST_IDLE;
      end
      default: state_d = kts_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kts_pkg::ST_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q <= n_d; lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; j_q <= j_d;
    frame_q <= frame_d; row_a_q <= row_a_d; row_b_q <= row_b_d;
    cnt_q <= cnt_d; w_q <= w_d; rem_q <= rem_d; den_q <= den_d;
    comp_q <= comp_d; phase_q <= phase_d; diff_q <= diff_d; acc_q <= acc_d;
    res_q <= res_d; found_q <= found_d;
  end

  assign done_o = done_q;
  assign found_o = found_q;
  assign out_pos_x_o = res_q[0];
  assign out_pos_y_o = res_q[1];
  assign out_pos_z_o = res_q[2];
  assign out_scale_x_o = res_q[3];
  assign out_scale_y_o = res_q[4];
  assign out_scale_z_o = res_q[5];
endmodule

>>> sv/kts_checker.sv
// Port-level checks for the keyframe track sampler, bound to the top level.
// Depends on keyframe_track_sampler_unit.
`timescale 1ns / 1ps
module kts_port_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic command_i,
  input logic done_o,
  input logic found_o,
  input logic [31:0] out_pos_x_o
);
  // A result beat never comes twice in a row.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  // A write beat finishes at once.
  a_write_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !command_i) |=> !busy_o) else $error("write stalled");
  // A sample beat makes the block busy.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i) |=> busy_o) else $error("sample not taken");
  // A result beat comes while the block is already free.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy at result");
  // Without keys the x position output is zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> out_pos_x_o == '0) else $error("nonzero miss");
endmodule

bind keyframe_track_sampler_unit kts_port_sva u_kts_checker (.*);

>>> dv/kts_checker.sv
// Checker for the keyframe track sampler: mirrors the key table and key_count,
// predicts each sample result and compares it with the result beats. Uses kts_pkg.
`timescale 1ns / 1ps
module kts_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic               command_i,
  input  logic [7:0]         key_index_i,
  input  logic [15:0]        key_time_i,
  input  logic signed [31:0] key_pos_x_i,
  input  logic signed [31:0] key_pos_y_i,
  input  logic signed [31:0] key_pos_z_i,
  input  logic signed [31:0] key_scale_x_i,
  input  logic signed [31:0] key_scale_y_i,
  input  logic signed [31:0] key_scale_z_i,
  input  logic [23:0]        frame_i,
  input  logic               key_count_we_i,
  input  logic [8:0]         key_count_i,
  input  logic               done_o,
  input  logic               found_o,
  input  logic signed [31:0] out_pos_x_o,
  input  logic signed [31:0] out_pos_y_o,
  input  logic signed [31:0] out_pos_z_o,
  input  logic signed [31:0] out_scale_x_o,
  input  logic signed [31:0] out_scale_y_o,
  input  logic signed [31:0] out_scale_z_o,
  output int                 failures,
  output int                 pending
);
  import kts_pkg::*;

  typedef struct {
    logic                     found;
    logic signed [CoordW-1:0] comp[CompN];
  } sample_t;

  logic [TimeW-1:0]         key_times[KeyDepth];
  logic signed [CoordW-1:0] key_comps[KeyDepth][CompN];
  logic [CntW-1:0]          mirror_count;
  sample_t                  expected_samples[$];

  // One blended component: a + floor((b - a) * w / 65536), split to stay in 64 bits.
  function automatic logic signed [CoordW-1:0] blend_comp(logic signed [CoordW-1:0] a,
                                                          logic signed [CoordW-1:0] b,
                                                          longint w);
    longint diff, hi, lo, stp;
    diff = longint'(b) - longint'(a);
    hi = diff >>> 16;
    lo = diff - hi * 65536;
    stp = hi * w + ((lo * w) >>> 16);
    return CoordW'(longint'(a) + stp);
  endfunction

  // Binary search for the bracketing keys, then return a key or blend two.
  function automatic sample_t sample_track(logic [FrameW-1:0] frame);
    sample_t r;
    int n, lo, hi, mid, j, k;
    longint fr, t0, t1, w;
    r.found = 1'b0;
    foreach (r.comp[c]) r.comp[c] = '0;
    n = (mirror_count > KeyDepth) ? KeyDepth : int'(mirror_count);
    if (n == 0) return r;
    r.found = 1'b1;
    fr = longint'(frame);
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if ((longint'(key_times[mid]) << 8) < fr) lo = mid + 1;
      else hi = mid;
    end
    j = lo;
    if (j == 0 || j == n || (longint'(key_times[j]) << 8) == fr) begin
      k = (j == n) ? n - 1 : j;
      foreach (r.comp[c]) r.comp[c] = key_comps[k][c];
      return r;
    end
    t0 = longint'(key_times[j-1]) << 8;
    t1 = longint'(key_times[j]) << 8;
    if (fr <= t0) begin
      foreach (r.comp[c]) r.comp[c] = key_comps[j-1][c];
      return r;
    end
    w = ((fr - t0) << 16) / (t1 - t0);
    foreach (r.comp[c]) r.comp[c] = blend_comp(key_comps[j-1][c], key_comps[j][c], w);
    return r;
  endfunction

  // Watch the channels: results first, then config and command beats.
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t got, want;
    if (!rst_ni) begin
      mirror_count <= '0;
      failures <= 0;
      pending <= 0;
    end else begin
      if (done_o) begin
        got.found = found_o;
        got.comp = '{out_pos_x_o, out_pos_y_o, out_pos_z_o,
                     out_scale_x_o, out_scale_y_o, out_scale_z_o};
        if (expected_samples.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          failures++;
        end else begin
          want = expected_samples.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            failures++;
          end
          foreach (want.comp[c]) begin
            if (got.comp[c] !== want.comp[c]) begin
              $display("%0t: component %0d expected %08h actual %08h",
                       $time, c, want.comp[c], got.comp[c]);
              failures++;
            end
          end
        end
      end
      if (key_count_we_i) mirror_count <= key_count_i;
      if (start_i && !busy_o) begin
        if (command_i == CMD_SAMPLE) begin
          expected_samples.push_back(sample_track(frame_i));
        end else begin
          key_times[key_index_i] = key_time_i;
          key_comps[key_index_i] = '{key_pos_x_i, key_pos_y_i, key_pos_z_i,
                                     key_scale_x_i, key_scale_y_i, key_scale_z_i};
        end
      end
      pending <= expected_samples.size();
    end
  end
endmodule

>>> dv/tb.sv
// Testbench top for keyframe_track_sampler_unit: clock, reset, key writes,
// samples and key_count settings. Uses kts_pkg and the kts_checker module.
`timescale 1ns / 1ps
module tb;
  import kts_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               command_i = CMD_WRITE;
  logic [7:0]         key_index_i = '0;
  logic [15:0]        key_time_i = '0;
  logic signed [31:0] key_pos_x_i = '0;
  logic signed [31:0] key_pos_y_i = '0;
  logic signed [31:0] key_pos_z_i = '0;
  logic signed [31:0] key_scale_x_i = '0;
  logic signed [31:0] key_scale_y_i = '0;
  logic signed [31:0] key_scale_z_i = '0;
  logic [23:0]        frame_i = '0;
  logic               key_count_we_i = 1'b0;
  logic [8:0]         key_count_i = '0;
  logic               done_o, found_o;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [31:0] out_scale_x_o, out_scale_y_o, out_scale_z_o;
  int                 failures, pending;

  logic [15:0] slot_times[KeyDepth];
  int          cur_count = 0;
  int          n_samples = 0;
  int          n_writes = 0;
  int          n_settings = 0;
  bit          no_gaps = 0;
  int          quiet_cycles = 0;

  keyframe_track_sampler_unit uut (.*);
  kts_checker chk (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return $signed($urandom());
    endcase
  endfunction

  // Random gap before the next beat, never during the no-gap stretch.
  task automatic maybe_gap();
    if (!no_gaps && $urandom_range(0, 99) < 32) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drive one command beat and hold it until the block takes it.
  task automatic issue(logic cmd, logic [7:0] slot, logic [15:0] ktime,
                       logic signed [31:0] p[6], logic [23:0] frame);
    maybe_gap();
    start_i <= 1'b1;
    command_i <= cmd;
    key_index_i <= slot;
    key_time_i <= ktime;
    key_pos_x_i <= p[0];
    key_pos_y_i <= p[1];
    key_pos_z_i <= p[2];
    key_scale_x_i <= p[3];
    key_scale_y_i <= p[4];
    key_scale_z_i <= p[5];
    frame_i <= frame;
    do @(posedge clk_i); while (busy_o);
    if (cmd == CMD_SAMPLE) n_samples++;
    else begin
      n_writes++;
      slot_times[slot] = ktime;
    end
  endtask

  task automatic write_key(logic [7:0] slot, logic [15:0] ktime);
    logic signed [31:0] p[6];
    foreach (p[c]) p[c] = rand_coord();
    issue(CMD_WRITE, slot, ktime, p, 24'($urandom()));
  endtask

  task automatic sample_at(logic [23:0] frame);
    logic signed [31:0] p[6];
    foreach (p[c]) p[c] = $signed($urandom());
    issue(CMD_SAMPLE, 8'($urandom()), 16'($urandom()), p, frame);
  endtask

  // Let the block drain, then write key_count while it is idle.
  task automatic set_count(int value);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    key_count_we_i <= 1'b1;
    key_count_i <= value[8:0];
    @(posedge clk_i);
    key_count_we_i <= 1'b0;
    cur_count = (value > KeyDepth) ? KeyDepth : value;
    n_settings++;
  endtask

  // Frame near a stored key, between keys, or anywhere.
  function automatic logic [23:0] pick_frame();
    int k;
    k = $urandom_range(0, (cur_count > 0) ? cur_count - 1 : 0);
    case ($urandom_range(0, 9))
      0, 1: return {slot_times[k], 8'h00};
      2: return 24'(longint'(slot_times[k]) * 256 - $urandom_range(1, 255));
      3: return 24'($urandom());
      4: return ($urandom_range(0, 1) != 0) ? 24'hffffff : 24'h0;
      default: return 24'(longint'(slot_times[k]) * 256 + $urandom_range(1, 60000));
    endcase
  endfunction

  initial begin
    int cnt;
    logic [23:0] corner_frames[6];
    corner_frames = '{24'h0, 24'h80, 24'h800000, 24'hfffeff, 24'hffff00, 24'hffffff};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty track, then two keys at the time extremes with extreme coords.
    sample_at(24'h001000);
    issue(CMD_WRITE, 8'd0, 16'h0000, '{32'sh7fffffff, 32'sh80000000, 32'sh0,
          32'sh7fffffff, 32'sh80000000, 32'sh1}, 24'h0);
    issue(CMD_WRITE, 8'd1, 16'hffff, '{32'sh80000000, 32'sh7fffffff, 32'shffffffff,
          32'sh80000000, 32'sh7fffffff, 32'sh0}, 24'hffffff);
    issue(CMD_WRITE, 8'd255, 16'hffff, '{32'sh1, 32'sh2, 32'sh3, 32'sh4, 32'sh5, 32'sh6},
          24'h0);
    set_count(1);
    sample_at(24'h0);
    sample_at(24'hffffff);
    set_count(2);
    foreach (corner_frames[i]) sample_at(corner_frames[i]);
    // Equal key times: a frame on them returns the first key, one past them the last.
    write_key(8'd1, 16'h0000);
    sample_at(24'h0);
    sample_at(24'h10);

    // Fill the whole table with ascending times.
    for (int s = 0; s < KeyDepth; s++) write_key(s[7:0], 16'(s * 200 + $urandom_range(0, 199)));

    // Phases of writes and samples over several key counts.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: cnt = 256;
        1: cnt = 511;
        2: cnt = 257;
        3: cnt = 1;
        4: cnt = 0;
        5: cnt = 2;
        6, 7: cnt = $urandom_range(3, 20);
        13: cnt = 8;
        default: cnt = $urandom_range(1, 300);
      endcase
      set_count(cnt);
      no_gaps = (ph == 9 || ph == 10);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 5) == 0 || (ph == 13 && i < 8)) begin
          int s;
          s = (ph == 13) ? ((i < 8) ? i : $urandom_range(0, 7)) : $urandom_range(0, 255);
          if (ph == 13) write_key(s[7:0], 16'($urandom()));
          else if (s > 0 && $urandom_range(0, 7) == 0) write_key(s[7:0], slot_times[s-1]);
          else write_key(s[7:0], 16'(s * 200 + $urandom_range(0, 199)));
        end else begin
          sample_at(pick_frame());
        end
      end
    end

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d samples and %0d key writes over %0d key_count settings.",
             n_samples, n_writes, n_settings);
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
